// ===== design/sbps_pkg.sv =====
// sbps_pkg: shared types and constants for the scope block parser and scaler
// no dependencies; imported by every module of the block
`default_nettype none

package sbps_pkg;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] SCAN_DIGITS = 4'd4;

  localparam int LEN_W  = 30;
  localparam int SCAN_W = 14;
  localparam int IDX_W  = 12;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [2:0] CFG_CHAN_MASK  = 3'd0;
  localparam logic [2:0] CFG_EXP_POINTS = 3'd1;
  localparam logic [2:0] CFG_SCALE0     = 3'd2;
  localparam logic [2:0] CFG_SCALE3     = 3'd5;

  typedef enum logic [3:0] {
    PH_HDR,
    PH_DIGCNT,
    PH_LEN,
    PH_DATA,
    PH_TAIL,
    PH_SCAN,
    PH_SCAN_HASH,
    PH_SCAN_NUM,
    PH_SKIP
  } phase_e;

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_EVENT,
    KIND_ERROR
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_HEADER,
    ERR_DIGITS,
    ERR_TAIL
  } err_e;

  typedef struct packed {
    kind_e             kind;
    logic [1:0]        chan;
    logic [IDX_W-1:0]  idx;
    logic [7:0]        data;
    logic              last;
    err_e              err;
  } q_entry_t;

  typedef logic [3:0][63:0] scale_arr_t;

endpackage

`default_nettype wire

// ===== design/sbps_front.sv =====
// sbps_front: byte parser; walks block headers, lengths, tails and resync scan
// depends on sbps_pkg; pushes sample, event and error beats into sbps_queue
`default_nettype none

module sbps_front
  import sbps_pkg::*;
#(
  parameter int MAX_POINTS = 4096,
  parameter int CHANNELS   = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              q_full_i,
  input  wire logic [3:0]        chan_mask_i,
  input  wire logic [SCAN_W-1:0] expected_points_i,
  output logic                   push_o,
  output q_entry_t               entry_o
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [3:0] CH_MASK = 4'((1 << CHANNELS) - 1);

  function automatic logic [2:0] next_above(input logic [3:0] m, input logic [1:0] ch);
    logic [2:0] r;
    r = '0;
    for (int i = 3; i >= 0; i--) begin
      if (m[i] && (2'(i) > ch)) r = {1'b1, 2'(i)};
    end
    return r;
  endfunction

  function automatic logic [2:0] lowest(input logic [3:0] m);
    logic [2:0] r;
    r = '0;
    for (int i = 3; i >= 0; i--) begin
      if (m[i]) r = {1'b1, 2'(i)};
    end
    return r;
  endfunction

  phase_e             phase_q, phase_d;
  logic [1:0]         chan_q, chan_d;
  logic [3:0]         digits_q, digits_d;
  logic [LEN_W-1:0]   len_acc_q, len_acc_d;
  logic [LEN_W-1:0]   bytes_left_q, bytes_left_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [SCAN_W-1:0]  scan_q, scan_d;

  logic               acc;
  logic               is_digit;
  logic [3:0]         digit;
  logic [3:0]         mask_eff;
  logic [2:0]         low;
  logic [2:0]         nxt_cur;
  logic [2:0]         nxt_low;
  logic [LEN_W-1:0]   len_new;
  logic [SCAN_W-1:0]  scan_new;
  logic [3:0]         digits_dec;

  assign acc        = in_valid_i && !q_full_i;
  assign is_digit   = data_byte_i inside {[CH_ZERO:CH_NINE]};
  assign digit      = data_byte_i[3:0];
  assign mask_eff   = chan_mask_i & CH_MASK;
  assign low        = lowest(mask_eff);
  assign nxt_cur    = next_above(mask_eff, chan_q);
  assign nxt_low    = next_above(mask_eff, low[1:0]);
  assign len_new    = (len_acc_q << 3) + (len_acc_q << 1) + LEN_W'(digit);
  assign scan_new   = (scan_q << 3) + (scan_q << 1) + SCAN_W'(digit);
  assign digits_dec = digits_q - 4'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HDR;
      chan_q       <= '0;
      digits_q     <= '0;
      len_acc_q    <= '0;
      bytes_left_q <= '0;
      count_q      <= '0;
      scan_q       <= '0;
    end else begin
      phase_q      <= phase_d;
      chan_q       <= chan_d;
      digits_q     <= digits_d;
      len_acc_q    <= len_acc_d;
      bytes_left_q <= bytes_left_d;
      count_q      <= count_d;
      scan_q       <= scan_d;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    chan_d       = chan_q;
    digits_d     = digits_q;
    len_acc_d    = len_acc_q;
    bytes_left_d = bytes_left_q;
    count_d      = count_q;
    scan_d       = scan_q;
    push_o       = 1'b0;
    entry_o      = '{kind: KIND_SAMPLE, chan: '0, idx: '0, data: '0, last: 1'b0,
                     err: ERR_NONE};
    if (acc) begin
      case (phase_q)
        PH_HDR: begin
          if (data_byte_i == CH_HASH) begin
            phase_d = PH_DIGCNT;
          end else begin
            push_o       = 1'b1;
            entry_o.kind = KIND_ERROR;
            entry_o.chan = chan_q;
            entry_o.err  = ERR_HEADER;
            phase_d      = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (data_byte_i == CH_HASH) begin
            chan_d  = low[2] ? low[1:0] : 2'd0;
            phase_d = low[2] ? PH_DIGCNT : PH_TAIL;
          end
        end
        PH_DIGCNT: begin
          if (data_byte_i inside {[CH_ONE:CH_NINE]}) begin
            digits_d  = digit;
            len_acc_d = '0;
            phase_d   = PH_LEN;
          end else begin
            push_o       = 1'b1;
            entry_o.kind = KIND_ERROR;
            entry_o.chan = chan_q;
            entry_o.err  = ERR_DIGITS;
            phase_d      = PH_SKIP;
          end
        end
        PH_LEN: begin
          if (!is_digit) begin
            push_o       = 1'b1;
            entry_o.kind = KIND_ERROR;
            entry_o.chan = chan_q;
            entry_o.err  = ERR_DIGITS;
            phase_d      = PH_SKIP;
          end else begin
            len_acc_d = len_new;
            digits_d  = digits_dec;
            if (digits_dec == 4'd0) begin
              bytes_left_d = len_new;
              count_d      = '0;
              if (len_new == '0) begin
                chan_d  = nxt_cur[2] ? nxt_cur[1:0] : chan_q;
                phase_d = nxt_cur[2] ? PH_HDR : PH_TAIL;
              end else begin
                phase_d = PH_DATA;
              end
            end
          end
        end
        PH_DATA: begin
          if (count_q < CNT_W'(MAX_POINTS)) begin
            push_o       = 1'b1;
            entry_o.kind = KIND_SAMPLE;
            entry_o.chan = chan_q;
            entry_o.idx  = IDX_W'(count_q);
            entry_o.data = data_byte_i;
            entry_o.last = (bytes_left_q == LEN_W'(1)) ||
                           (count_q == CNT_W'(MAX_POINTS - 1));
            count_d      = count_q + CNT_W'(1);
          end
          bytes_left_d = bytes_left_q - LEN_W'(1);
          if (bytes_left_q == LEN_W'(1)) begin
            chan_d  = nxt_cur[2] ? nxt_cur[1:0] : chan_q;
            phase_d = nxt_cur[2] ? PH_HDR : PH_TAIL;
          end
        end
        PH_TAIL: begin
          if (data_byte_i == CH_NL) begin
            push_o       = 1'b1;
            entry_o.kind = KIND_EVENT;
            chan_d       = low[2] ? low[1:0] : 2'd0;
            phase_d      = low[2] ? PH_HDR : PH_TAIL;
          end else if (data_byte_i == CH_COLON) begin
            phase_d = PH_SCAN;
          end else begin
            push_o       = 1'b1;
            entry_o.kind = KIND_ERROR;
            entry_o.chan = chan_q;
            entry_o.err  = ERR_TAIL;
            phase_d      = PH_SKIP;
          end
        end
        PH_SCAN: begin
          if (data_byte_i == CH_HASH) phase_d = PH_SCAN_HASH;
        end
        PH_SCAN_HASH: begin
          if (data_byte_i == CH_FOUR) begin
            phase_d  = PH_SCAN_NUM;
            digits_d = SCAN_DIGITS;
            scan_d   = '0;
          end else if (data_byte_i != CH_HASH) begin
            phase_d = PH_SCAN;
          end
        end
        PH_SCAN_NUM: begin
          if (!is_digit) begin
            phase_d = (data_byte_i == CH_HASH) ? PH_SCAN_HASH : PH_SCAN;
          end else begin
            scan_d   = scan_new;
            digits_d = digits_dec;
            if (digits_dec == 4'd0) begin
              if (scan_new != expected_points_i) begin
                phase_d = PH_SCAN;
              end else begin
                push_o       = 1'b1;
                entry_o.kind = KIND_EVENT;
                if (low[2]) begin
                  chan_d       = low[1:0];
                  bytes_left_d = LEN_W'(scan_new);
                  count_d      = '0;
                  if (scan_new == '0) begin
                    chan_d  = nxt_low[2] ? nxt_low[1:0] : low[1:0];
                    phase_d = nxt_low[2] ? PH_HDR : PH_TAIL;
                  end else begin
                    phase_d = PH_DATA;
                  end
                end else begin
                  chan_d  = 2'd0;
                  phase_d = PH_TAIL;
                end
              end
            end
          end
        end
        default: begin
          chan_d  = low[2] ? low[1:0] : 2'd0;
          phase_d = low[2] ? PH_HDR : PH_TAIL;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/sbps_queue.sv =====
// sbps_queue: short fifo between the parser and the scaler
// depends on sbps_pkg for the entry type and depth
`default_nettype none

module sbps_queue
  import sbps_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  q_entry_t      entry_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output q_entry_t      entry_o
);

  q_entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (do_push && !do_pop) count_q <= count_q + QCNT_W'(1);
      else if (do_pop && !do_push) count_q <= count_q - QCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== design/sbps_back.sv =====
// sbps_back: two-stage scaler; multiply by gain, then shift, offset and saturate
// depends on sbps_pkg; pops beats from sbps_queue and holds the result register
`default_nettype none

module sbps_back
  import sbps_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         q_valid_i,
  input  q_entry_t          q_entry_i,
  output logic              q_pop_o,
  input  scale_arr_t        scale_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [1:0]        kind_o,
  output logic [1:0]        chan_o,
  output logic [IDX_W-1:0]  sample_index_o,
  output logic [31:0]       amplitude_o,
  output logic              last_in_block_o,
  output logic [1:0]        error_code_o
);

  logic                s1_valid_q;
  q_entry_t            s1_entry_q;
  logic signed [39:0]  s1_prod_q;
  logic signed [31:0]  s1_off_q;

  logic                out_valid_q;
  q_entry_t            out_entry_q;
  logic [31:0]         out_amp_q;

  logic                s2_adv, s1_adv;
  logic [63:0]         scale_sel;
  logic signed [7:0]   sample_s;
  logic signed [31:0]  gain_s;
  logic signed [39:0]  prod;
  logic signed [23:0]  quo;
  logic signed [33:0]  sum;
  logic [31:0]         amp_sat;

  assign s2_adv    = !out_valid_q || !out_stall_i;
  assign s1_adv    = !s1_valid_q || s2_adv;
  assign q_pop_o   = q_valid_i && s1_adv;

  assign scale_sel = scale_i[q_entry_i.chan];
  assign sample_s  = q_entry_i.data;
  assign gain_s    = scale_sel[63:32];
  assign prod      = sample_s * gain_s;

  assign quo = s1_prod_q[39:16];
  assign sum = 34'(quo) + 34'(s1_off_q);

  always_comb begin
    if (s1_entry_q.kind != KIND_SAMPLE) begin
      amp_sat = '0;
    end else if (sum > 34'sd2147483647) begin
      amp_sat = 32'h7FFF_FFFF;
    end else if (sum < -34'sd2147483648) begin
      amp_sat = 32'h8000_0000;
    end else begin
      amp_sat = sum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_q <= q_valid_i;
      if (s2_adv) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_entry_q <= q_entry_i;
      s1_prod_q  <= prod;
      s1_off_q   <= scale_sel[31:0];
    end
    if (s1_valid_q && s2_adv) begin
      out_entry_q <= s1_entry_q;
      out_amp_q   <= amp_sat;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_entry_q.kind;
  assign chan_o          = out_entry_q.chan;
  assign sample_index_o  = out_entry_q.idx;
  assign amplitude_o     = out_amp_q;
  assign last_in_block_o = out_entry_q.last;
  assign error_code_o    = out_entry_q.err;

endmodule

`default_nettype wire

// ===== design/scope_block_parse_scale.sv =====
// scope_block_parse_scale: top level; configuration registers, parser, queue, scaler
// depends on sbps_pkg, sbps_front, sbps_queue and sbps_back
// The block takes one stream byte per cycle, sustained: the parser decides on each byte
// in the cycle it is accepted and pushes at most one beat into a four-entry queue. The
// scaler pops one beat per cycle while the output does not stall, multiplies the sample by
// the channel gain in its first stage and applies shift, offset and saturation in its
// second. The input stalls only while that queue is full, which happens only when the
// output side stalls. Configuration writes are always ready and are meant to be issued
// while no bytes are in flight.
`default_nettype none

module scope_block_parse_scale
  import sbps_pkg::*;
#(
  parameter int MAX_POINTS = 4096,
  parameter int CHANNELS   = 4
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [7:0]   data_byte_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [1:0]        kind_o,
  output logic [1:0]        chan_o,
  output logic [11:0]       sample_index_o,
  output logic signed [31:0] amplitude_o,
  output logic              last_in_block_o,
  output logic [1:0]        error_code_o,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [63:0]  cfg_data_i
);

  logic [3:0]         chan_mask_q;
  logic [SCAN_W-1:0]  exp_points_q;
  scale_arr_t         scale_q;

  logic               q_full;
  logic               push;
  q_entry_t           push_entry;
  logic               q_valid;
  q_entry_t           q_entry;
  logic               q_pop;
  logic [31:0]        amp;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_mask_q  <= 4'hF;
      exp_points_q <= SCAN_W'(1000);
      scale_q      <= {4{64'd65536}};
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_CHAN_MASK) begin
        chan_mask_q <= cfg_data_i[3:0];
      end else if (cfg_index_i == CFG_EXP_POINTS) begin
        exp_points_q <= cfg_data_i[SCAN_W-1:0];
      end else if (cfg_index_i inside {[CFG_SCALE0:CFG_SCALE3]}) begin
        scale_q[2'(cfg_index_i - CFG_SCALE0)] <= cfg_data_i;
      end
    end
  end

  sbps_front #(
    .MAX_POINTS(MAX_POINTS),
    .CHANNELS  (CHANNELS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .data_byte_i      (data_byte_i),
    .q_full_i         (q_full),
    .chan_mask_i      (chan_mask_q),
    .expected_points_i(exp_points_q),
    .push_o           (push),
    .entry_o          (push_entry)
  );

  sbps_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .entry_o(q_entry)
  );

  sbps_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_entry_i      (q_entry),
    .q_pop_o        (q_pop),
    .scale_i        (scale_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .chan_o         (chan_o),
    .sample_index_o (sample_index_o),
    .amplitude_o    (amp),
    .last_in_block_o(last_in_block_o),
    .error_code_o   (error_code_o)
  );

  assign amplitude_o = amp;

endmodule

`default_nettype wire

// ===== test/scope_block_parse_scale_tb.sv =====
// scope_block_parse_scale_tb: self-checking bench for the scope block parser and scaler
// feeds byte streams with random gaps and output stalls and predicts every result beat
// depends on sbps_pkg and scope_block_parse_scale
`timescale 1ns / 100ps

module scope_block_parse_scale_tb;
  import sbps_pkg::*;

  localparam int MAX_POINTS = 4096;
  localparam int CHANNELS = 4;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 12;
  localparam int STREAM_BYTES = 1500;
  localparam longint AMP_MAX = 64'sd2147483647;
  localparam longint AMP_MIN = -64'sd2147483648;

  typedef struct {
    kind_e kind;
    logic [1:0] chan;
    logic [11:0] pos;
    logic [31:0] amp;
    logic last;
    err_e err;
  } parsed_beat_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] kind_out;
  logic [1:0] chan_out;
  logic [11:0] index_out;
  logic signed [31:0] amp_out;
  logic last_out;
  logic [1:0] err_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // parser state and register copies
  phase_e parse_phase;
  logic [1:0] blk_chan;
  logic [3:0] digits_todo;
  logic [29:0] length_sum;
  logic [29:0] bytes_todo;
  logic [12:0] samples_out;
  logic [13:0] scan_sum;
  logic [3:0] mask_cfg;
  logic [13:0] points_cfg;
  scale_arr_t scale_cfg;

  parsed_beat_t beats_due[$];
  int fail_count = 0;
  int busy_bytes = 0;
  int cycle_count = 0;
  int in_gap_pct = 20;
  int out_hold_pct = 20;
  bit no_gaps = 1'b0;

  scope_block_parse_scale #(
    .MAX_POINTS(MAX_POINTS),
    .CHANNELS  (CHANNELS)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (in_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind_out),
    .chan_o         (chan_out),
    .sample_index_o (index_out),
    .amplitude_o    (amp_out),
    .last_in_block_o(last_out),
    .error_code_o   (err_out),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int first_chan();
    for (int i = 0; i < CHANNELS; i++) begin
      if (mask_cfg[i]) return i;
    end
    return -1;
  endfunction

  function automatic void start_event();
    int c;
    c = first_chan();
    if (c >= 0) begin
      blk_chan = 2'(c);
      parse_phase = PH_HDR;
    end else begin
      blk_chan = '0;
      parse_phase = PH_TAIL;
    end
  endfunction

  function automatic void next_chan();
    for (int i = int'(blk_chan) + 1; i < CHANNELS; i++) begin
      if (mask_cfg[i]) begin
        blk_chan = 2'(i);
        parse_phase = PH_HDR;
        return;
      end
    end
    parse_phase = PH_TAIL;
  endfunction

  function automatic void start_data(input logic [29:0] len);
    bytes_todo = len;
    samples_out = '0;
    if (len == 0) next_chan();
    else parse_phase = PH_DATA;
  endfunction

  function automatic void push_beat(input kind_e kind, input logic [1:0] chan,
                                    input logic [11:0] pos, input logic [31:0] amp,
                                    input logic last, input err_e err);
    parsed_beat_t t;
    t.kind = kind;
    t.chan = chan;
    t.pos = pos;
    t.amp = amp;
    t.last = last;
    t.err = err;
    beats_due = {beats_due, t};
  endfunction

  function automatic void flag_error(input err_e code);
    push_beat(KIND_ERROR, blk_chan, '0, '0, 1'b0, code);
    parse_phase = PH_SKIP;
  endfunction

  function automatic logic [31:0] scale_byte(input logic [7:0] b, input logic [1:0] ch);
    longint gain;
    longint offs;
    longint prod;
    longint v;
    gain = longint'($signed(scale_cfg[ch][63:32]));
    offs = longint'($signed(scale_cfg[ch][31:0]));
    prod = longint'($signed(b)) * gain;
    v = (prod >>> 16) + offs;
    if (v > AMP_MAX) v = AMP_MAX;
    if (v < AMP_MIN) v = AMP_MIN;
    return v[31:0];
  endfunction

  function automatic void model_reset();
    mask_cfg = 4'hF;
    points_cfg = 14'd1000;
    for (int i = 0; i < 4; i++) scale_cfg[i] = 64'd65536;
    digits_todo = '0;
    length_sum = '0;
    bytes_todo = '0;
    samples_out = '0;
    scan_sum = '0;
    start_event();
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    logic is_dig;
    logic [3:0] d;
    logic last;
    int c;
    is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
    d = 4'(b - CH_ZERO);
    case (parse_phase)
      PH_HDR: begin
        if (b == CH_HASH) parse_phase = PH_DIGCNT;
        else flag_error(ERR_HEADER);
      end
      PH_SKIP: begin
        if (b == CH_HASH) begin
          c = first_chan();
          if (c >= 0) begin
            blk_chan = 2'(c);
            parse_phase = PH_DIGCNT;
          end else begin
            blk_chan = '0;
            parse_phase = PH_TAIL;
          end
        end
      end
      PH_DIGCNT: begin
        if (b >= CH_ONE && b <= CH_NINE) begin
          digits_todo = d;
          length_sum = '0;
          parse_phase = PH_LEN;
        end else begin
          flag_error(ERR_DIGITS);
        end
      end
      PH_LEN: begin
        if (!is_dig) begin
          flag_error(ERR_DIGITS);
        end else begin
          length_sum = 30'(length_sum * 10 + d);
          digits_todo = digits_todo - 4'd1;
          if (digits_todo == 0) start_data(length_sum);
        end
      end
      PH_DATA: begin
        if (samples_out < MAX_POINTS) begin
          last = (bytes_todo == 1) || (samples_out + 1 == MAX_POINTS);
          push_beat(KIND_SAMPLE, blk_chan, samples_out[11:0], scale_byte(b, blk_chan), last,
                    ERR_NONE);
          samples_out = samples_out + 13'd1;
        end
        bytes_todo = bytes_todo - 30'd1;
        if (bytes_todo == 0) next_chan();
      end
      PH_TAIL: begin
        if (b == CH_NL) begin
          push_beat(KIND_EVENT, '0, '0, '0, 1'b0, ERR_NONE);
          start_event();
        end else if (b == CH_COLON) begin
          parse_phase = PH_SCAN;
        end else begin
          flag_error(ERR_TAIL);
        end
      end
      PH_SCAN: begin
        if (b == CH_HASH) parse_phase = PH_SCAN_HASH;
      end
      PH_SCAN_HASH: begin
        if (b == CH_FOUR) begin
          parse_phase = PH_SCAN_NUM;
          digits_todo = SCAN_DIGITS;
          scan_sum = '0;
        end else if (b != CH_HASH) begin
          parse_phase = PH_SCAN;
        end
      end
      PH_SCAN_NUM: begin
        if (!is_dig) begin
          parse_phase = (b == CH_HASH) ? PH_SCAN_HASH : PH_SCAN;
        end else begin
          scan_sum = 14'(scan_sum * 10 + d);
          digits_todo = digits_todo - 4'd1;
          if (digits_todo == 0) begin
            if (scan_sum != points_cfg) begin
              parse_phase = PH_SCAN;
            end else begin
              push_beat(KIND_EVENT, '0, '0, '0, 1'b0, ERR_NONE);
              c = first_chan();
              if (c >= 0) begin
                blk_chan = 2'(c);
                start_data(30'(scan_sum));
              end else begin
                blk_chan = '0;
                parse_phase = PH_TAIL;
              end
            end
          end
        end
      end
      default: start_event();
    endcase
  endfunction

  // result side: random stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!no_gaps && $urandom_range(0, 99) < out_hold_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_beat();
    parsed_beat_t want;
    if (beats_due.size() == 0) begin
      $display("%0t: unexpected beat, expected none, actual kind %0d", $time, kind_out);
      fail_count++;
    end else begin
      want = beats_due.pop_front();
      compare_field("kind", want.kind, kind_out);
      compare_field("chan", want.chan, chan_out);
      compare_field("sample_index", want.pos, index_out);
      compare_field("amplitude", want.amp, amp_out);
      compare_field("last_in_block", want.last, last_out);
      compare_field("error_code", want.err, err_out);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_beat();
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    if (!no_gaps && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (parse_phase != PH_SKIP && parse_phase != PH_SCAN) busy_bytes++;
    parse_byte(b);
  endtask

  task automatic send_digits(input int value, input int n);
    int p;
    for (int k = n - 1; k >= 0; k--) begin
      p = 1;
      repeat (k) p = p * 10;
      send_byte(8'(CH_ZERO + (value / p) % 10));
    end
  endtask

  task automatic send_samples(input int n);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_block(input int ndig, input int len);
    send_byte(CH_HASH);
    send_byte(8'(CH_ZERO + ndig));
    send_digits(len, ndig);
    send_samples(len);
  endtask

  task automatic send_match();
    send_byte(CH_HASH);
    send_byte(CH_FOUR);
    send_digits(int'(points_cfg), 4);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_CHAN_MASK) mask_cfg = val[3:0];
    else if (idx == CFG_EXP_POINTS) points_cfg = val[13:0];
    else if (idx >= CFG_SCALE0 && idx <= CFG_SCALE3) scale_cfg[idx - CFG_SCALE0] = val;
    @(posedge clk);
  endtask

  function automatic logic [7:0] non_hash_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_HASH);
    return b;
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    case ($urandom_range(0, 5))
      0: w = 32'h7FFF_FFFF;
      1: w = 32'h8000_0000;
      2: w = '0;
      3: w = $urandom;
      default: begin
        w = $urandom_range(0, 1 << 18);
        if ($urandom_range(0, 1)) w = -w;
      end
    endcase
    return w;
  endfunction

  function automatic void pick_length(output int ndig, output int len);
    int top;
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) ndig = $urandom_range(1, 2);
    else if (r < 95) ndig = $urandom_range(3, 4);
    else ndig = $urandom_range(5, 9);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 12);
    top = (ndig == 1) ? 9 : 99;
    if (len > top) len = top;
  endfunction

  // continue the stream from wherever the parser stands; a partly read nonzero length is cut off with a colon
  task automatic next_piece();
    int ndig;
    int len;
    case (parse_phase)
      PH_HDR: begin
        pick_length(ndig, len);
        send_block(ndig, len);
      end
      PH_SKIP: begin
        repeat ($urandom_range(0, 3)) send_byte(non_hash_byte());
        send_byte(CH_HASH);
      end
      PH_DIGCNT: begin
        pick_length(ndig, len);
        send_byte(8'(CH_ZERO + ndig));
        send_digits(len, ndig);
        send_samples(len);
      end
      PH_LEN: begin
        if (length_sum != 0) begin
          send_byte(":");
        end else begin
          while (parse_phase == PH_LEN && digits_todo > 1) send_byte(CH_ZERO);
          if (parse_phase == PH_LEN) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        end
      end
      PH_DATA: send_samples(int'(bytes_todo));
      PH_TAIL: begin
        if ($urandom_range(0, 99) < 85) begin
          send_byte(CH_NL);
        end else begin
          send_byte(CH_COLON);
          repeat ($urandom_range(0, 3)) send_byte(non_hash_byte());
          if ($urandom_range(0, 1)) begin
            send_byte(CH_HASH);
            send_byte(CH_HASH);
            send_byte(CH_FOUR);
            send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
            send_byte(CH_COLON);
          end
          send_match();
        end
      end
      default: send_match();
    endcase
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 4))
      0: send_byte(CH_HASH);
      1: send_byte(CH_COLON);
      2: send_byte(CH_NL);
      3: send_byte(CH_ZERO);
      default: send_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic randomize_config();
    cfg_write(CFG_CHAN_MASK, 64'($urandom_range(0, 15)));
    cfg_write(CFG_EXP_POINTS, 64'($urandom_range(0, 40)));
    for (int ch = 0; ch < 4; ch++) cfg_write(3'(CFG_SCALE0 + ch), {rand_word(), rand_word()});
    case ($urandom_range(0, 2))
      0: in_gap_pct = 0;
      1: in_gap_pct = 15;
      default: in_gap_pct = 40;
    endcase
    case ($urandom_range(0, 2))
      0: out_hold_pct = 0;
      1: out_hold_pct = 15;
      default: out_hold_pct = 40;
    endcase
  endtask

  // reset register values: zero gain, offset 65536
  task automatic test_reset_defaults();
    send_byte(CH_HASH);
    send_byte("1");
    send_byte("4");
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_block(1, 1);
    send_block(1, 0);
    send_block(2, 12);
    send_byte(CH_NL);
  endtask

  task automatic test_error_recovery();
    send_byte("A");
    send_byte("z");
    send_byte(CH_HASH);
    send_byte(CH_ZERO);
    send_byte(CH_HASH);
    send_byte("x");
    send_byte(CH_HASH);
    send_byte("2");
    send_byte("1");
    send_byte("q");
    send_block(1, 0);
    send_block(1, 1);
    send_block(1, 0);
    send_block(1, 0);
    send_byte("Q");
    send_byte(CH_NL);
    send_byte(CH_HASH);
    send_byte(CH_ONE);
    send_byte(CH_ZERO);
    send_block(1, 0);
    send_block(1, 0);
    send_block(1, 0);
    send_byte(CH_NL);
  endtask

  task automatic test_scale_extremes();
    settle();
    cfg_write(CFG_SCALE0, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
    cfg_write(3'(CFG_SCALE0 + 1), {32'h8000_0000, 32'h8000_0000});
    cfg_write(3'(CFG_SCALE0 + 2), {32'h0000_0000, 32'($urandom)});
    cfg_write(CFG_SCALE3, {32'hFFFF_FFFF, 32'h0000_0000});
    for (int ch = 0; ch < 4; ch++) begin
      send_byte(CH_HASH);
      send_byte(CH_ONE);
      send_byte("5");
      send_byte(8'h00);
      send_byte(8'h7F);
      send_byte(8'h80);
      send_byte(8'hFF);
      send_byte(8'h01);
    end
    send_byte(CH_NL);
  endtask

  task automatic test_mask_change();
    settle();
    cfg_write(CFG_CHAN_MASK, 64'b0011);
    send_block(1, 2);
    settle();
    cfg_write(CFG_CHAN_MASK, 64'b1000);
    send_block(1, 1);
    send_block(1, 1);
    send_byte(CH_NL);
  endtask

  task automatic test_resync();
    settle();
    cfg_write(CFG_CHAN_MASK, 64'b0010);
    cfg_write(CFG_EXP_POINTS, 64'd3);
    send_block(1, 3);
    send_byte(CH_COLON);
    send_byte("x");
    send_byte(CH_HASH);
    send_byte(CH_HASH);
    send_byte(CH_FOUR);
    send_byte("1");
    send_byte("2");
    send_byte(CH_COLON);
    send_byte(CH_HASH);
    send_byte(CH_FOUR);
    send_digits(4, 4);
    send_match();
    send_samples(3);
    send_byte(CH_NL);
    // no active channel: events hold only the tail
    settle();
    cfg_write(CFG_CHAN_MASK, 64'b0000);
    cfg_write(CFG_EXP_POINTS, 64'd9999);
    send_byte("A");
    send_byte(CH_HASH);
    send_byte("Z");
    send_byte(CH_HASH);
    send_byte(CH_COLON);
    send_match();
    send_byte(CH_NL);
    // point count out of reach of four digits
    settle();
    cfg_write(CFG_EXP_POINTS, 64'h3FFF);
    send_byte(CH_COLON);
    send_byte(CH_HASH);
    send_byte(CH_FOUR);
    send_digits(9999, 4);
    settle();
    cfg_write(CFG_EXP_POINTS, 64'd0);
    send_match();
    send_byte(CH_NL);
  endtask

  task automatic test_capacity();
    settle();
    cfg_write(CFG_CHAN_MASK, 64'b0001);
    in_gap_pct = 5;
    out_hold_pct = 5;
    // close the empty event so the next block starts on channel 0
    send_byte(CH_NL);
    send_block(4, MAX_POINTS + 4);
    send_byte(CH_NL);
    send_block(9, MAX_POINTS);
    send_byte(CH_NL);
  endtask

  task automatic test_random_stream();
    int pieces;
    pieces = 0;
    busy_bytes = 0;
    while (busy_bytes < STREAM_BYTES) begin
      if (pieces % 24 == 0) begin
        settle();
        randomize_config();
      end
      if (busy_bytes > STREAM_BYTES - 300) no_gaps = 1'b1;
      if ($urandom_range(0, 99) < 6) send_noise();
      else next_piece();
      pieces++;
    end
  endtask

  initial begin
    model_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_error_recovery();
    test_scale_extremes();
    test_mask_change();
    test_resync();
    test_capacity();
    test_random_stream();
    no_gaps = 1'b1;
    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
